// ===== hdl/urs_pkg.sv =====
// Shared constants for the ultrasonic ranging sequencer.
// Used by urs_div.sv and ultrasonic_ranging_sequencer.sv; no dependencies.

package urs_pkg;

    // Number of sensors served round-robin
    localparam int NUM_SENSORS_DEF = 6;
    localparam int NUM_SENSORS_MAX = 16;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SENSOR_W = 3;
    localparam int TIME_W   = 32;
    localparam int MASK_W   = 6;
    localparam int MM_W     = 16;
    localparam int CPU_W    = 8;

    // Stream words
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Event kinds
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_TIMER = 2'd1;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd2;

    // Register file
    localparam int               APB_ADDR_W     = 3;
    localparam int               APB_DATA_W     = 32;
    localparam logic             REG_CYCLES_PER_US = 1'b0;
    localparam logic [CPU_W-1:0] CPU_RESET      = 8'd48;

    // Distance scaling: mm = floor(len * 10 / (cycles_per_us * 29))
    localparam int MM_SCALE   = 10;
    localparam int MM_DIVIDER = 29;

    // Serial divider sizing: 36-bit dividend, 13-bit divisor (255 * 29 < 8192)
    localparam int DIVIDEND_W = TIME_W + 4;
    localparam int DIVISOR_W  = 13;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

endpackage

// ===== hdl/ultrasonic_ranging_sequencer.sv =====
// Top level of the ultrasonic ranging sequencer: sensor phases, pin masks,
// echo time store and the event sequencer. Depends on urs_pkg and urs_div.
//
//  channel   dir  handshake               word contents
//  s_axis    in   tvalid/tready           tuser: op; tdata: sensor, now
//  m_axis    out  tvalid/tready           tuser: distance_valid; tdata: masks,
//                                          restart, sensor, distance
//  apb       in   psel/penable, pready=1  cycles_per_us at byte address 0
//
// Timer events, ticks without a distance, echo starts, ignored edges and unused
// kinds go straight to the output stage; an echo end takes a store read, then
// a length write. A tick that reports a distance waits for the 36-step serial
// divider. Reset is synchronous and clears phases, masks and the round-robin
// pointer; the echo store needs no clearing. A stalled output holds its word;
// the next word is accepted meanwhile and waits in the sequencer until the
// output register frees.

module ultrasonic_ranging_sequencer #(
    parameter int NUM_SENSORS = urs_pkg::NUM_SENSORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input events
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [urs_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [2:0] sensor, [34:3] now
    input  logic [urs_pkg::S_TUSER_W-1:0]   s_axis_tuser,   // [1:0] op
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] pin_level_mask, [11:6] pin_output_mask, [17:12] echo_listen_mask,
    // [18] restart_timer, [21:19] distance_sensor, [37:22] distance_mm
    output logic [urs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [urs_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // [0] distance_valid
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [urs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [urs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [urs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int SEL_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_TRIG_DELAY = 3'd2,
        PH_TRIG_HIGH  = 3'd3,
        PH_TRIG_DONE  = 3'd4,
        PH_ECHO_START = 3'd5,
        PH_ECHO_END   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_EDGE,
        S_SCALE,
        S_DIV,
        S_DONE
    } t_state;

    // control state
    t_state                         r_state, n_state;
    t_phase                         r_phase [NUM_SENSORS];
    t_phase                         n_phase [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]         r_level, n_level;
    logic [NUM_SENSORS-1:0]         r_dir, n_dir;
    logic [SEL_W-1:0]               r_next, n_next;
    logic [urs_pkg::CPU_W-1:0]      r_cpu;

    // per-item working registers
    logic [SEL_W-1:0]               r_sel, n_sel;
    logic [urs_pkg::TIME_W-1:0]     r_now, n_now;
    logic                           r_restart, n_restart;
    logic                           r_dvalid, n_dvalid;
    logic [urs_pkg::MM_W-1:0]       r_mm, n_mm;

    // output register
    logic                           r_out_valid;
    logic [urs_pkg::M_TDATA_W-1:0]  r_out_data;
    logic                           r_out_user;

    // echo time store: start time, then overwritten by the echo length
    logic [urs_pkg::TIME_W-1:0]     r_echo_mem [NUM_SENSORS];
    logic [urs_pkg::TIME_W-1:0]     r_rd;
    logic                           mem_we;
    logic [SEL_W-1:0]               mem_wa;
    logic [urs_pkg::TIME_W-1:0]     mem_wd;

    // divider hookup
    logic                           div_start;
    logic                           div_done;
    logic [urs_pkg::DIVIDEND_W-1:0] div_num;
    logic [urs_pkg::DIVISOR_W-1:0]  div_den;
    logic [urs_pkg::DIVIDEND_W-1:0] div_quo;

    // input fields
    logic [urs_pkg::OP_W-1:0]       in_op;
    logic [urs_pkg::SENSOR_W-1:0]   in_sensor;
    logic [urs_pkg::TIME_W-1:0]     in_now;
    logic [SEL_W-1:0]               in_idx;
    logic                           in_ok;
    logic                           accept;
    logic                           out_free;

    // output masks
    logic [NUM_SENSORS-1:0]         listen;
    logic [urs_pkg::MASK_W-1:0]     level_m, dir_m, listen_m;
    logic [urs_pkg::SENSOR_W-1:0]   dsens;

    assign in_op     = s_axis_tuser[urs_pkg::OP_W-1:0];
    assign in_sensor = s_axis_tdata[urs_pkg::SENSOR_W-1:0];
    assign in_now    = s_axis_tdata[urs_pkg::SENSOR_W +: urs_pkg::TIME_W];
    assign in_idx    = SEL_W'(in_sensor);
    assign in_ok     = (32'(in_sensor) < NUM_SENSORS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == urs_pkg::REG_CYCLES_PER_US)
                  ? urs_pkg::APB_DATA_W'(r_cpu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu <= urs_pkg::CPU_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == urs_pkg::REG_CYCLES_PER_US) begin
            r_cpu <= pwdata[urs_pkg::CPU_W-1:0];
        end
    end

    // listening sensors and 6-bit views of the per-sensor bits
    always_comb begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
            listen[k] = (r_phase[k] == PH_TRIG_DONE) || (r_phase[k] == PH_ECHO_START);
        end
    end

    generate
        for (genvar b = 0; b < urs_pkg::MASK_W; b++) begin : g_mask
            if (b < NUM_SENSORS) begin : g_on
                assign level_m[b]  = r_level[b];
                assign dir_m[b]    = r_dir[b];
                assign listen_m[b] = listen[b];
            end else begin : g_off
                assign level_m[b]  = 1'b0;
                assign dir_m[b]    = 1'b0;
                assign listen_m[b] = 1'b0;
            end
        end
    endgenerate

    assign dsens = r_dvalid ? urs_pkg::SENSOR_W'(r_sel) : '0;

    // scaled echo length and combined divisor (10 * len) / (29 * cycles_per_us)
    assign div_num = urs_pkg::DIVIDEND_W'(r_rd) * urs_pkg::DIVIDEND_W'(urs_pkg::MM_SCALE);
    assign div_den = urs_pkg::DIVISOR_W'(r_cpu) * urs_pkg::DIVISOR_W'(urs_pkg::MM_DIVIDER);
    assign div_start = (r_state == S_SCALE);

    urs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer next-state logic
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_level   = r_level;
        n_dir     = r_dir;
        n_next    = r_next;
        n_sel     = r_sel;
        n_now     = r_now;
        n_restart = r_restart;
        n_dvalid  = r_dvalid;
        n_mm      = r_mm;
        mem_we    = 1'b0;
        mem_wa    = r_sel;
        mem_wd    = r_now - r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_restart = 1'b0;
                    n_dvalid  = 1'b0;
                    n_mm      = '0;
                    n_state   = S_DONE;
                    priority if (in_op == urs_pkg::OP_TICK) begin
                        // serve the round-robin sensor and re-trigger it
                        n_sel = r_next;
                        if (r_phase[r_next] == PH_ECHO_END) begin
                            n_dvalid = 1'b1;
                            n_state  = S_RDWAIT;
                        end
                        n_dir[r_next]   = 1'b1;
                        n_level[r_next] = 1'b0;
                        n_phase[r_next] = PH_TRIG_DELAY;
                        n_restart       = 1'b1;
                        n_next = (32'(r_next) == NUM_SENSORS - 1) ? '0 : r_next + 1'b1;
                    end else if (in_op == urs_pkg::OP_TIMER) begin
                        // raise waiting trigger pins, release raised ones
                        for (int k = 0; k < NUM_SENSORS; k++) begin
                            if (r_phase[k] == PH_TRIG_DELAY) begin
                                n_level[k] = 1'b1;
                                n_phase[k] = PH_TRIG_HIGH;
                                n_restart  = 1'b1;
                            end else if (r_phase[k] == PH_TRIG_HIGH) begin
                                n_level[k] = 1'b0;
                                n_dir[k]   = 1'b0;
                                n_phase[k] = PH_TRIG_DONE;
                            end
                        end
                    end else if (in_op == urs_pkg::OP_EDGE) begin
                        // echo start stamps the time; echo end needs a store read
                        if (in_ok) begin
                            n_sel = in_idx;
                            n_now = in_now;
                            if (r_phase[in_idx] == PH_TRIG_DONE) begin
                                mem_we          = 1'b1;
                                mem_wa          = in_idx;
                                mem_wd          = in_now;
                                n_phase[in_idx] = PH_ECHO_START;
                            end else if (r_phase[in_idx] == PH_ECHO_START) begin
                                n_phase[in_idx] = PH_ECHO_END;
                                n_state         = S_RDWAIT;
                            end
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RDWAIT: begin
                n_state = r_dvalid ? S_SCALE : S_EDGE;
            end
            S_EDGE: begin
                // length modulo 2^32
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_SCALE: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_mm    = (|div_quo[urs_pkg::DIVIDEND_W-1:urs_pkg::MM_W])
                            ? '1 : div_quo[urs_pkg::MM_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_dir       <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_phase[k] <= PH_IDLE;
            end
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_dir     <= n_dir;
            r_next    <= n_next;
            r_sel     <= n_sel;
            r_now     <= n_now;
            r_restart <= n_restart;
            r_dvalid  <= n_dvalid;
            r_mm      <= n_mm;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_user  <= r_dvalid;
                r_out_data  <= urs_pkg::M_TDATA_W'({r_mm, dsens, r_restart,
                                                   listen_m, dir_m, level_m});
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // echo store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_echo_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_echo_mem[r_sel];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== hdl/urs_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on urs_pkg for the dividend, divisor and counter widths.

module urs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [urs_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [urs_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [urs_pkg::DIVIDEND_W-1:0]   o_quotient
);

    logic [urs_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_done;
    logic [urs_pkg::DIVIDEND_W-1:0] r_work;
    logic [urs_pkg::DIVISOR_W-1:0]  r_rem;
    logic [urs_pkg::DIVISOR_W-1:0]  r_den;

    logic [urs_pkg::DIVISOR_W:0]    partial;
    logic [urs_pkg::DIVISOR_W:0]    diff;
    logic                           ge;

    // one trial subtraction per cycle
    always_comb begin
        partial = {r_rem, r_work[urs_pkg::DIVIDEND_W-1]};
        ge      = (partial >= {1'b0, r_den});
        diff    = partial - {1'b0, r_den};
    end

    // dividend shifts out the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= urs_pkg::DIV_CNT_W'(urs_pkg::DIV_STEPS);
                r_work <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_work <= {r_work[urs_pkg::DIVIDEND_W-2:0], ge};
                r_rem  <= ge ? diff[urs_pkg::DIVISOR_W-1:0]
                             : partial[urs_pkg::DIVISOR_W-1:0];
                if (r_cnt == urs_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

// ===== test/ultrasonic_ranging_sequencer_tb.sv =====
// Self-checking testbench for ultrasonic_ranging_sequencer: drives event words and
// APB writes, and predicts every result word with a scoreboard class.
// Depends on urs_pkg and the ultrasonic_ranging_sequencer RTL.
`timescale 1ns / 100ps

module ultrasonic_ranging_sequencer_tb;

    localparam int NSENS = urs_pkg::NUM_SENSORS_DEF;
    localparam logic [urs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 80;

    // per-sensor ranging phases
    typedef enum logic [2:0] {
        PH_IDLE, PH_MUST_TRIG, PH_TRIG_DELAY, PH_TRIG_HIGH,
        PH_TRIG_DONE, PH_ECHO_START, PH_ECHO_END
    } t_ranging_phase;

    typedef struct packed {
        logic [urs_pkg::MASK_W-1:0]   level;
        logic [urs_pkg::MASK_W-1:0]   drive;
        logic [urs_pkg::MASK_W-1:0]   listen;
        logic                         restart;
        logic                         valid;
        logic [urs_pkg::SENSOR_W-1:0] dsens;
        logic [urs_pkg::MM_W-1:0]     mm;
    } t_ranging_word;

    // Tracks sensor phases and pin masks, and holds the result words still owed
    class t_ranging_board;
        t_ranging_phase             phase [NSENS];
        logic [urs_pkg::TIME_W-1:0] echo_start [NSENS];
        logic [urs_pkg::TIME_W-1:0] echo_len [NSENS];
        int                         pointer;
        logic [NSENS-1:0]           level_bits;
        logic [NSENS-1:0]           drive_bits;
        logic [urs_pkg::CPU_W-1:0]  divisor;
        t_ranging_word              owed_words [$];
        int                         errors;

        function new();
            foreach (phase[i]) begin
                phase[i] = PH_IDLE;
                echo_start[i] = '0;
                echo_len[i] = '0;
            end
            pointer = 0;
            level_bits = '0;
            drive_bits = '0;
            divisor = urs_pkg::CPU_RESET;
            errors = 0;
        endfunction

        function void set_divisor(logic [urs_pkg::CPU_W-1:0] value);
            divisor = value;
        endfunction

        function int waiting();
            return owed_words.size();
        endfunction

        function logic [urs_pkg::SENSOR_W-1:0] next_up();
            return urs_pkg::SENSOR_W'((pointer < NSENS) ? pointer : 0);
        endfunction

        // floor(floor(len*10/divisor)/29), saturated; zero divisor saturates
        function logic [urs_pkg::MM_W-1:0] cycles_to_mm(logic [urs_pkg::TIME_W-1:0] len);
            logic [63:0] q;
            if (divisor == '0)
                return '1;
            q = ({32'b0, len} * 64'd10) / {56'b0, divisor};
            q = q / 64'd29;
            return (q > 64'hFFFF) ? '1 : q[urs_pkg::MM_W-1:0];
        endfunction

        // Advance the sensor state for one accepted event and queue its result
        function void note_event(logic [urs_pkg::OP_W-1:0] op,
                                 logic [urs_pkg::SENSOR_W-1:0] sen,
                                 logic [urs_pkg::TIME_W-1:0] now);
            t_ranging_word w;
            int idx;
            w = '0;
            case (op)
                urs_pkg::OP_TICK: begin
                    idx = (pointer < NSENS) ? pointer : 0;
                    if (phase[idx] == PH_ECHO_END) begin
                        w.valid = 1'b1;
                        w.dsens = urs_pkg::SENSOR_W'(idx);
                        w.mm    = cycles_to_mm(echo_len[idx]);
                    end
                    drive_bits[idx] = 1'b1;
                    level_bits[idx] = 1'b0;
                    phase[idx] = PH_TRIG_DELAY;
                    w.restart = 1'b1;
                    pointer = (idx + 1) % NSENS;
                end
                urs_pkg::OP_TIMER: begin
                    // a pin going high this event does not also drop this event
                    for (int i = 0; i < NSENS; i++) begin
                        if (phase[i] == PH_TRIG_DELAY) begin
                            level_bits[i] = 1'b1;
                            phase[i] = PH_TRIG_HIGH;
                            w.restart = 1'b1;
                        end else if (phase[i] == PH_TRIG_HIGH) begin
                            level_bits[i] = 1'b0;
                            drive_bits[i] = 1'b0;
                            phase[i] = PH_TRIG_DONE;
                        end
                    end
                end
                urs_pkg::OP_EDGE: begin
                    if (sen < NSENS) begin
                        if (phase[sen] == PH_TRIG_DONE) begin
                            echo_start[sen] = now;
                            phase[sen] = PH_ECHO_START;
                        end else if (phase[sen] == PH_ECHO_START) begin
                            echo_len[sen] = now - echo_start[sen];
                            phase[sen] = PH_ECHO_END;
                        end
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < NSENS; i++)
                w.listen[i] = (phase[i] == PH_TRIG_DONE) || (phase[i] == PH_ECHO_START);
            w.level = level_bits;
            w.drive = drive_bits;
            owed_words.push_back(w);
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
        endtask

        // Compare one result word against the oldest owed word
        task check_word(logic [urs_pkg::M_TDATA_W-1:0] data, logic flag);
            t_ranging_word w;
            if (owed_words.size() == 0) begin
                report($sformatf("unexpected result word 0x%0h", data));
                return;
            end
            w = owed_words.pop_front();
            check_field("pin_level_mask", data[5:0], w.level);
            check_field("pin_output_mask", data[11:6], w.drive);
            check_field("echo_listen_mask", data[17:12], w.listen);
            check_field("restart_timer", data[18], w.restart);
            check_field("distance_valid", flag, w.valid);
            check_field("distance_sensor", data[21:19], w.dsens);
            check_field("distance_mm", data[37:22], w.mm);
        endtask
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [urs_pkg::S_TDATA_W-1:0]     s_axis_tdata = '0;   // [2:0] sensor, [34:3] now
    logic [urs_pkg::S_TUSER_W-1:0]     s_axis_tuser = '0;   // [1:0] op
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [5:0] level, [11:6] output, [17:12] listen, [18] restart,
    // [21:19] distance_sensor, [37:22] distance_mm
    logic [urs_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic [urs_pkg::M_TUSER_W-1:0]     m_axis_tuser;        // [0] distance_valid
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [urs_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [urs_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [urs_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    // steady stretches: no gaps on that side
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    t_ranging_board ranger = new();

    ultrasonic_ranging_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ranger.check_word(m_axis_tdata, m_axis_tuser[0]);
    end

    // Result sink with random stalls per word
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Send one event word; the prediction is made at acceptance
    task automatic send_event(input logic [urs_pkg::OP_W-1:0] op,
                              input logic [urs_pkg::SENSOR_W-1:0] sen,
                              input logic [urs_pkg::TIME_W-1:0] now);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, now, sen};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ranger.note_event(op, sen, now);
    endtask

    // Hold off the sender until every owed word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ranger.waiting() > 0);
    endtask

    // APB write of cycles_per_us: setup cycle, then access cycle
    task automatic write_divisor(input logic [urs_pkg::CPU_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= urs_pkg::APB_ADDR_W'(4 * urs_pkg::REG_CYCLES_PER_US);
        pwdata  <= urs_pkg::APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ranger.set_divisor(value);
    endtask

    // Mostly full trigger/echo rounds with random content, plus loose events
    task automatic run_random(input int count);
        int done;
        int len_sel;
        bit paused;
        logic [urs_pkg::OP_W-1:0] op;
        logic [urs_pkg::SENSOR_W-1:0] k;
        logic [urs_pkg::TIME_W-1:0] t0;
        logic [urs_pkg::TIME_W-1:0] len;
        done = 0;
        paused = 1'b0;
        while (done < count) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0) begin
                k = ranger.next_up();
                send_event(urs_pkg::OP_TICK, urs_pkg::SENSOR_W'($urandom_range(0, 7)),
                           $urandom);
                send_event(urs_pkg::OP_TIMER, urs_pkg::SENSOR_W'($urandom_range(0, 7)),
                           $urandom);
                send_event(urs_pkg::OP_TIMER, urs_pkg::SENSOR_W'($urandom_range(0, 7)),
                           $urandom);
                t0 = $urandom;
                len_sel = $urandom_range(0, 3);
                case (len_sel)
                    0: len = $urandom_range(0, 2000);
                    1: len = $urandom_range(0, 200000);
                    2: len = $urandom_range(0, 20000000);
                    default: len = $urandom;
                endcase
                send_event(urs_pkg::OP_EDGE, k, t0);
                send_event(urs_pkg::OP_EDGE, k, t0 + len);
                done += 5;
            end else begin
                op = urs_pkg::OP_W'($urandom_range(0, 3));
                send_event(op, urs_pkg::SENSOR_W'($urandom_range(0, 7)), $urandom);
                if (op == urs_pkg::OP_TICK || op == urs_pkg::OP_TIMER)
                    done++;
            end
            if (!paused && done >= count / 2) begin
                paused = 1'b1;
                drain();
            end
        end
    endtask

    // Main sequence
    initial begin
        int settings [5];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset divisor
        send_event(OP_UNUSED, 3'd7, 32'hFFFF_FFFF);            // unused kind
        send_event(urs_pkg::OP_EDGE, 3'd7, 32'h0);             // unknown sensors
        send_event(urs_pkg::OP_EDGE, 3'd6, 32'h1234_5678);
        send_event(urs_pkg::OP_TIMER, 3'd0, 32'h0);            // timer with nothing pending
        send_event(urs_pkg::OP_EDGE, 3'd0, 32'h10);            // edge while idle
        send_event(urs_pkg::OP_TICK, 3'd0, 32'h100);           // sensor 0 triggered
        send_event(urs_pkg::OP_EDGE, 3'd0, 32'h200);           // edge during trigger delay
        send_event(urs_pkg::OP_TIMER, 3'd0, 32'h300);          // sensor 0 high
        send_event(urs_pkg::OP_TICK, 3'd0, 32'h400);           // sensor 1 triggered
        send_event(urs_pkg::OP_TIMER, 3'd0, 32'h500);          // 0 done, 1 only goes high
        send_event(urs_pkg::OP_TIMER, 3'd0, 32'h600);          // 1 done
        send_event(urs_pkg::OP_EDGE, 3'd0, 32'hFFFF_FFF0);     // echo across counter wrap
        send_event(urs_pkg::OP_EDGE, 3'd0, 32'h0000_0010);
        send_event(urs_pkg::OP_EDGE, 3'd1, 32'h0);             // longest echo
        send_event(urs_pkg::OP_EDGE, 3'd1, 32'hFFFF_FFFF);
        send_event(urs_pkg::OP_EDGE, 3'd0, 32'h700);           // edge after echo ended
        repeat (4) send_event(urs_pkg::OP_TICK, 3'd5, 32'h800); // sensors 2..5
        send_event(urs_pkg::OP_TICK, 3'd0, 32'h900);           // distance of sensor 0
        send_event(urs_pkg::OP_TICK, 3'd0, 32'hA00);           // saturated distance, sensor 1
        drain();

        settings[0] = 1;
        settings[1] = 255;
        settings[2] = 0;                              // zero divisor saturates
        settings[3] = $urandom_range(2, 254);
        settings[4] = 48;
        foreach (settings[n]) begin
            write_divisor(urs_pkg::CPU_W'(settings[n]));
            run_random(PHASE_WORDS);
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (ranger.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/urs_pkg.sv
hdl/urs_div.sv
hdl/ultrasonic_ranging_sequencer.sv
test/ultrasonic_ranging_sequencer_tb.sv
